### rtl/rkcpd_pkg.sv
// Package for the rain kernel convolution / peak detect block.
// Widths, register and function codes, FSM states and inter-module structs.
// No dependencies.
package rkcpd_pkg;

    localparam int MAX_TAPS   = 256;
    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int FILL_W     = TAP_W + 1;
    localparam int RAIN_BITS  = 16;
    localparam int COEF_BITS  = 16;
    localparam int RAIN_FRAC  = 4;
    localparam int OUT_FRAC   = 16;
    localparam int PROD_W     = RAIN_BITS + COEF_BITS;
    localparam int ACC_W      = PROD_W + TAP_W;
    localparam int OUT_W      = 48;
    localparam int OUT_RSHIFT = RAIN_FRAC + COEF_BITS - OUT_FRAC;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_KLEN = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SKIP = 1'b1;

    localparam logic FUNC_COEF = 1'b0;
    localparam logic FUNC_RAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic rotate;   // ring shift toward cell 0, cell 0 wraps to the far end
        logic insert;   // shift away from cell 0, new sample enters cell 0
    } t_cell_ctl;

    typedef struct packed {
        logic                 en;
        logic [TAP_W-1:0]     addr;
        logic [COEF_BITS-1:0] data;
    } t_coef_wr;

    typedef struct packed {
        logic             clear;
        logic             en;
        logic [TAP_W-1:0] rd_addr;
    } t_mac_ctl;

endpackage

### rtl/rain_kernel_convolution_peak_detect.sv
// Top level: rain history ring of cells, MAC unit, sequencer, peak tracking.
// Depends on rkcpd_pkg, rkcpd_cell, rkcpd_mac.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata, tuser, tlast
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata, tuser
//  cfg       in   i_cfg_we (no wait)             i_cfg_addr, i_cfg_wdata
//
// Coefficient items are accepted back to back in the idle state. A rain item runs
// through the turn, drain and finish states: the history ring makes one full turn past
// the single multiplier, one lag per cycle, then the drain state empties the multiply pipeline.
// Reset is synchronous; the history ring and coefficient memory are not
// cleared (a fill count masks stale history). A stalled output holds the
// result; the next item is still accepted and its work runs up to the end.
module rain_kernel_convolution_peak_detect
    import rkcpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [39:0]           s_axis_tdata,  // coef_index[7:0], coef_value[23:8],
                                                 // rain_mm[39:24]
    input  logic [1:0]            s_axis_tuser,  // func[0], in_window[1]
    input  logic                  s_axis_tlast,  // end_of_series
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [95:0]           m_axis_tdata,  // mobility_value[47:0],
                                                 // peak_value[95:48]
    output logic                  m_axis_tuser   // peak_found
);

    t_state                r_state, n_state;
    logic [TAP_W-1:0]      r_cnt, n_cnt;
    logic [CFG_DATA_W-1:0] r_klen;
    logic                  r_skip;
    logic [RAIN_BITS-1:0]  r_rain;
    logic                  r_win;
    logic                  r_eos;
    logic [FILL_W-1:0]     r_fill;
    logic [OUT_W-1:0]      r_last;
    logic [OUT_W-1:0]      r_before;
    logic                  r_last_win;
    logic [1:0]            r_seen;
    logic                  r_out_valid;
    logic [OUT_W-1:0]      r_out_y;
    logic                  r_out_pk;
    logic [OUT_W-1:0]      r_out_pv;

    logic                  w_in_acc;
    logic                  w_rain_acc;
    logic                  w_rot;
    logic                  w_finish;
    logic [FILL_W-1:0]     w_taps;
    logic [FILL_W-1:0]     w_lag_m1;
    logic [ACC_W-1:0]      w_acc;
    logic [OUT_W-1:0]      w_y;
    logic                  w_peak;
    t_cell_ctl             w_cell_ctl;
    t_coef_wr              w_wr;
    t_mac_ctl              w_mac_ctl;
    logic [RAIN_BITS-1:0]  w_q [MAX_TAPS];

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_rain_acc = w_in_acc && (s_axis_tuser[0] == FUNC_RAIN);

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        w_rot         = 1'b0;
        w_finish      = 1'b0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_rain_acc) begin
                    n_state = ST_RUN;
                    n_cnt   = '0;
                end
            end
            ST_RUN: begin
                w_rot = 1'b1;
                n_cnt = r_cnt + TAP_W'(1);
                if (r_cnt == TAP_W'(MAX_TAPS - 1)) begin
                    n_state = ST_DRAIN;
                    n_cnt   = '0;
                end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + TAP_W'(1);
                if (r_cnt == TAP_W'(1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_finish = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- configuration ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen <= CFG_DATA_W'(MAX_TAPS);
            r_skip <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_KLEN: r_klen <= i_cfg_wdata;
                CFG_SKIP: r_skip <= i_cfg_wdata[0];
                default:  ;
            endcase
        end
    end

    // ---- latched sample ----
    always_ff @(posedge i_clk) begin
        if (w_rain_acc) begin
            r_rain <= s_axis_tdata[39:24];
            r_win  <= s_axis_tuser[1];
            r_eos  <= s_axis_tlast;
        end
    end

    // ---- history ring ----
    assign w_cell_ctl.rotate = w_rot;
    assign w_cell_ctl.insert = w_finish;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic [RAIN_BITS-1:0] w_lo;
        logic [RAIN_BITS-1:0] w_hi;
        if (k == 0) begin : g_head
            assign w_lo = r_rain;
        end else begin : g_body
            assign w_lo = w_q[k-1];
        end
        if (k == MAX_TAPS - 1) begin : g_tail
            assign w_hi = w_q[0];
        end else begin : g_mid
            assign w_hi = w_q[k+1];
        end
        rkcpd_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_cell_ctl),
            .i_from_lo (w_lo),
            .i_from_hi (w_hi),
            .o_q       (w_q[k])
        );
    end

    // ---- multiply-accumulate ----
    // during turn step j, cell 0 holds the sample of lag j+1
    assign w_taps   = (r_klen > CFG_DATA_W'(MAX_TAPS)) ? FILL_W'(MAX_TAPS)
                                                       : FILL_W'(r_klen);
    assign w_lag_m1 = FILL_W'(r_cnt);

    assign w_wr.en   = w_in_acc && (s_axis_tuser[0] == FUNC_COEF);
    assign w_wr.addr = s_axis_tdata[7:0];
    assign w_wr.data = s_axis_tdata[23:8];

    assign w_mac_ctl.clear   = w_rain_acc;
    assign w_mac_ctl.en      = (r_state == ST_RUN) &&
                               ((w_lag_m1 + FILL_W'(1)) < w_taps) &&
                               (w_lag_m1 < r_fill);
    assign w_mac_ctl.rd_addr = r_cnt + TAP_W'(1);

    rkcpd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_ctl   (w_mac_ctl),
        .i_rain  (w_q[0]),
        .o_acc   (w_acc)
    );

    // sum stays below 2^(ACC_W-OUT_RSHIFT) < 2^48, so no clipping occurs
    assign w_y    = OUT_W'(w_acc >> OUT_RSHIFT);
    assign w_peak = (r_seen == 2'd2) && (r_last > r_before) && (w_y < r_last) &&
                    !(r_skip && r_last_win);

    // ---- peak tracking ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_last     <= '0;
            r_before   <= '0;
            r_last_win <= 1'b0;
            r_seen     <= '0;
        end else if (w_finish) begin
            if (r_eos) begin
                r_fill     <= '0;
                r_last     <= '0;
                r_before   <= '0;
                r_last_win <= 1'b0;
                r_seen     <= '0;
            end else begin
                if (r_fill < FILL_W'(MAX_TAPS)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
                r_before   <= r_last;
                r_last     <= w_y;
                r_last_win <= r_win;
                if (r_seen != 2'd2) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_y  <= w_y;
            r_out_pk <= w_peak;
            r_out_pv <= w_peak ? r_last : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_pv, r_out_y};
    assign m_axis_tuser  = r_out_pk;

    // ---- checks ----
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_FINISH))
        else $error("result appeared outside finish step");

    a_run_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt != TAP_W'(MAX_TAPS - 1)) |=>
        (r_state == ST_RUN && r_cnt == $past(r_cnt) + TAP_W'(1)))
        else $error("ring turn skipped a step");

    a_no_peak_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[95:48] == '0))
        else $error("peak value without peak");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FILL_W'(MAX_TAPS)) && (r_seen != 2'd3))
        else $error("history fill or sample count out of range");

    a_mac_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_FINISH) |-> !w_mac_ctl.en)
        else $error("accumulate enabled outside the turn");

endmodule

### rtl/rkcpd_cell.sv
// One rain history cell: holds one sample, shifts either way to a neighbor.
// Depends on rkcpd_pkg.
module rkcpd_cell
    import rkcpd_pkg::*;
(
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [RAIN_BITS-1:0] i_from_lo,
    input  logic [RAIN_BITS-1:0] i_from_hi,
    output logic [RAIN_BITS-1:0] o_q
);

    logic [RAIN_BITS-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_q <= i_from_lo;
        end else if (i_ctl.rotate) begin
            r_q <= i_from_hi;
        end
    end

    assign o_q = r_q;

endmodule

### rtl/rkcpd_mac.sv
// Coefficient memory and the shared multiply-accumulate pipeline.
// Depends on rkcpd_pkg.
module rkcpd_mac
    import rkcpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_coef_wr             i_wr,
    input  t_mac_ctl             i_ctl,
    input  logic [RAIN_BITS-1:0] i_rain,
    output logic [ACC_W-1:0]     o_acc
);

    logic [COEF_BITS-1:0] r_coef [MAX_TAPS];
    logic [COEF_BITS-1:0] r_coef_rd;
    logic [RAIN_BITS-1:0] r_rain_a;
    logic                 r_v_a;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_v_b;
    logic [ACC_W-1:0]     r_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_coef[i_wr.addr] <= i_wr.data;
        end
    end

    // stage A: coefficient read lines up with the sample leaving cell 0
    always_ff @(posedge i_clk) begin
        r_coef_rd <= r_coef[i_ctl.rd_addr];
        r_rain_a  <= i_rain;
        r_prod    <= PROD_W'(r_coef_rd) * PROD_W'(r_rain_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
        end else begin
            r_v_a <= i_ctl.en;
            r_v_b <= r_v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (r_v_b) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

### tb/sv/rkcpd_mobility_checker.sv
`timescale 1ns / 100ps
// Checker for rain_kernel_convolution_peak_detect: follows register writes and
// accepted items, predicts each mobility result and compares it field by field.
// Depends on rkcpd_pkg.
module rkcpd_mobility_checker
    import rkcpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [39:0]           i_in_data,   // coef_index[7:0], coef_value[23:8],
                                               // rain_mm[39:24]
    input  logic [1:0]            i_in_user,   // func[0], in_window[1]
    input  logic                  i_in_last,   // end_of_series
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [95:0]           i_out_data,  // mobility_value[47:0], peak_value[95:48]
    input  logic                  i_out_user,  // peak_found
    output int                    o_err_count,
    output int                    o_pending
);

    localparam int          TAPS       = 256;
    localparam int          PROD_SHIFT = 4;     // 20 fraction bits in the sum, 16 out
    localparam logic [47:0] SAT48      = '1;
    localparam int          MAX_PRINTS = 300;

    typedef struct packed {
        logic [47:0] mobility;
        logic        peak;
        logic [47:0] peak_val;
    } t_rain_result;

    t_rain_result mobility_due[$];

    logic [15:0] kernel_coef [TAPS];
    logic [15:0] rain_past   [TAPS];    // entry k: rain of sample t-1-k
    int          past_count;
    logic [47:0] prev_mob;
    logic [47:0] prev2_mob;
    logic        prev_in_win;
    int          series_pos;
    logic [8:0]  klen;
    logic        skip_win;

    function automatic logic [47:0] mobility_sum();
        int          taps;
        logic [63:0] acc;
        taps = (klen > TAPS) ? TAPS : klen;
        acc  = '0;
        for (int lag = 1; lag < taps; lag++) begin
            if (lag > past_count)
                break;
            acc = acc + kernel_coef[lag] * rain_past[lag - 1];
        end
        acc = acc >> PROD_SHIFT;
        return (acc > {16'd0, SAT48}) ? SAT48 : acc[47:0];
    endfunction

    task automatic compare_field(input string field, input logic [47:0] want,
                                 input logic [47:0] got);
        if (got !== want) begin
            o_err_count++;
            // log is capped, later mismatches are only counted
            if (o_err_count <= MAX_PRINTS)
                $display("%0t ns: %s mismatch, expected %h, got %h",
                         $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_rain_result want;
        t_rain_result got;
        logic [47:0]  y;

        if (!i_rst_n) begin
            mobility_due.delete();
            past_count  = 0;
            series_pos  = 0;
            prev_mob    = '0;
            prev2_mob   = '0;
            prev_in_win = 1'b0;
            klen        = 9'd256;
            skip_win    = 1'b1;
        end else begin
            // results first: an item accepted at this edge cannot be answered yet
            if (i_out_valid && i_out_ready) begin
                got.mobility = i_out_data[47:0];
                got.peak     = i_out_user;
                got.peak_val = i_out_data[95:48];
                if (mobility_due.size() == 0) begin
                    o_err_count++;
                    if (o_err_count <= MAX_PRINTS)
                        $display("%0t ns: result item with none expected, got %h %b %h",
                                 $time, got.mobility, got.peak, got.peak_val);
                end else begin
                    want = mobility_due.pop_front();
                    compare_field("mobility_value", want.mobility, got.mobility);
                    compare_field("peak_found", {47'd0, want.peak}, {47'd0, got.peak});
                    compare_field("peak_value", want.peak_val, got.peak_val);
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_KLEN: klen = i_cfg_wdata;
                    CFG_SKIP: skip_win = i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (i_in_valid && i_in_ready) begin
                if (i_in_user[0] == FUNC_COEF) begin
                    kernel_coef[i_in_data[7:0]] = i_in_data[23:8];
                end else begin
                    y = mobility_sum();
                    want.mobility = y;
                    want.peak     = series_pos >= 2 && prev_mob > prev2_mob && y < prev_mob
                                    && !(skip_win && prev_in_win);
                    want.peak_val = want.peak ? prev_mob : '0;
                    mobility_due.insert(mobility_due.size(), want);

                    for (int k = TAPS - 1; k > 0; k--)
                        rain_past[k] = rain_past[k - 1];
                    rain_past[0] = i_in_data[39:24];
                    if (past_count < TAPS)
                        past_count++;
                    prev2_mob   = prev_mob;
                    prev_mob    = y;
                    prev_in_win = i_in_user[1];
                    if (series_pos < 2)
                        series_pos++;

                    // end of series: history and peak tracking restart
                    if (i_in_last) begin
                        past_count  = 0;
                        series_pos  = 0;
                        prev_mob    = '0;
                        prev2_mob   = '0;
                        prev_in_win = 1'b0;
                    end
                end
            end
        end
        o_pending = mobility_due.size();
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the testbench for rain_kernel_convolution_peak_detect: clock, reset,
// register writes, input items, output back-pressure and the verdict.
// Depends on rkcpd_pkg, the block and rkcpd_mobility_checker.
module testbench;
    import rkcpd_pkg::*;

    localparam int DRAIN_CYCLES = MAX_TAPS + 44;   // one rain item plus margin
    localparam int TIMEOUT_NS   = 40_000_000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata  = '0;  // coef_index[7:0], coef_value[23:8],
                                                // rain_mm[39:24]
    logic [1:0]            s_axis_tuser  = '0;  // func[0], in_window[1]
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [95:0]           m_axis_tdata;        // mobility_value[47:0], peak_value[95:48]
    logic                  m_axis_tuser;        // peak_found

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count;
    int pending;

    rain_kernel_convolution_peak_detect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rkcpd_mobility_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_in_last   (s_axis_tlast),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // valid stays high from one item to the next unless an idle cycle falls between
    task automatic send_item(input logic func, input logic [7:0] idx, input logic [15:0] coef,
                             input logic [15:0] rain, input logic win, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {rain, coef, idx};
        s_axis_tuser  = {win, func};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_coef(input logic [7:0] idx, input logic [15:0] coef);
        send_item(FUNC_COEF, idx, coef, 16'($urandom_range(65535)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    endtask

    task automatic rain_sample(input logic [15:0] rain, input logic win, input logic last);
        send_item(FUNC_RAIN, 8'($urandom_range(255)), 16'($urandom_range(65535)), rain,
                  win, last);
    endtask

    function automatic logic [15:0] pick_word16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(255));
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // drop valid, wait for every result, then wait out DRAIN_CYCLES
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_item(input int end_pml);
        if ($urandom_range(99) < 18)
            load_coef(8'($urandom_range(255)), pick_word16());
        else
            rain_sample(pick_word16(), $urandom_range(99) < 30,
                        $urandom_range(999) < end_pml);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] klen, input logic skip_peaks,
                             input int src_pct, input int sink_pct, input int n_items,
                             input int end_pml);
        settle();
        write_reg(CFG_KLEN, klen);
        write_reg(CFG_SKIP, CFG_DATA_W'(skip_peaks));
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (n_items) random_item(end_pml);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // whole kernel first so no tap ever reads an unloaded coefficient
        for (int i = 0; i < MAX_TAPS; i++)
            load_coef(8'(i), (i == 1) ? 16'hFFFF : (i == 2) ? 16'h0000 : pick_word16());

        // series start, one- and two-sample series, extreme rain
        rain_sample(16'hFFFF, 1'b0, 1'b0);
        rain_sample(16'h0000, 1'b1, 1'b0);
        rain_sample(16'h0000, 1'b0, 1'b0);
        rain_sample(16'hFFFF, 1'b1, 1'b0);
        rain_sample(16'h0000, 1'b0, 1'b0);
        rain_sample(16'h0000, 1'b0, 1'b1);
        rain_sample(16'hFFFF, 1'b0, 1'b1);
        rain_sample(16'hFFFF, 1'b1, 1'b0);
        rain_sample(16'hFFFF, 1'b0, 1'b1);
        // extreme coefficients reloaded between two series
        load_coef(8'd255, 16'hFFFF);
        load_coef(8'd0, 16'hFFFF);
        load_coef(8'd1, 16'h0000);
        // impulses with window flags: peaks both in and out of a window
        for (int k = 0; k < 12; k++)
            rain_sample((k % 3 == 0) ? 16'hFFFF : 16'h0000, 1'(k % 2), k == 11);

        run_phase(9'd256, 1'b1, 0, 0, 100, 80);
        run_phase(9'd2, 1'b0, 63, 0, 90, 80);
        // long series across two phases so the history fills completely
        run_phase(9'd255, 1'b1, 0, 63, 280, 0);
        run_phase(9'd256, 1'b0, 22, 22, 150, 0);
        run_phase(9'd1, 1'b1, 0, 0, 40, 80);          // no taps at all
        run_phase(9'd511, 1'b0, 63, 0, 90, 60);       // beyond the tap count
        run_phase(CFG_DATA_W'($urandom_range(2, 256)), 1'b1, 0, 63, 90, 80);
        run_phase(9'd97, 1'b0, 22, 22, 90, 80);

        settle();
        if (err_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
